### rtl/rpn_pkg.sv
`default_nettype none
package rpn_pkg;

  typedef enum logic [1:0] {
    OPN_PUSH   = 2'd0,
    OPN_APPLY  = 2'd1,
    OPN_COPY   = 2'd2,
    OPN_REDUCE = 2'd3
  } opn_e;

  typedef enum logic [1:0] {
    AOP_ADD = 2'd0,
    AOP_SUB = 2'd1,
    AOP_MUL = 2'd2,
    AOP_DIV = 2'd3
  } aop_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_OVF  = 2'd2,
    ST_DIV0 = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         arith_op;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [6:0]         stack_depth;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [1:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] res;
    logic [1:0]         status;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_B,
    S_RD_A,
    S_WAIT_A,
    S_ALU,
    S_ALU_WAIT,
    S_WR,
    S_COPY,
    S_RD_TOP,
    S_TOP_WAIT,
    S_OUT
  } state_e;

endpackage
`default_nettype wire

### rtl/rpn_ram.sv
`default_nettype none
module rpn_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/rpn_alu.sv
`default_nettype none
// Shared unit: add/sub, multiply, and divide at one quotient bit a cycle.
module rpn_alu (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rpn_pkg::alu_req_t req_i,
  output rpn_pkg::alu_rsp_t     rsp_o
);
  import rpn_pkg::*;

  localparam int DivBits = 48;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIN} alu_st_e;

  alu_st_e              st_q, st_d;
  logic signed [63:0]   acc_q, acc_d;
  logic [47:0]          quo_q, quo_d;
  logic [47:0]          rem_q, rem_d;
  logic [47:0]          dvd_q, dvd_d;
  logic [31:0]          dvs_q;
  logic                 neg_q;
  logic [5:0]           cnt_q, cnt_d;
  logic signed [31:0]   res_q, res_d;
  logic [1:0]           sts_q, sts_d;
  logic                 done_q, done_d;

  logic [48:0]          rem_sh;
  logic [48:0]          rem_sub;
  logic signed [64:0]   sum;
  logic signed [63:0]   mag;
  logic signed [64:0]   sval;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  always_comb begin
    rem_sh  = {rem_q, dvd_q[47]};
    rem_sub = rem_sh - {17'd0, dvs_q};
  end

  always_comb begin
    st_d   = st_q;
    acc_d  = acc_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    cnt_d  = cnt_q;
    res_d  = res_q;
    sts_d  = sts_q;
    done_d = 1'b0;
    sum    = '0;
    mag    = '0;
    sval   = '0;
    unique case (st_q)
      A_IDLE: begin
        if (req_i.start) begin
          sts_d = ST_OK;
          unique case (aop_e'(req_i.op))
            AOP_ADD, AOP_SUB: begin
              if (aop_e'(req_i.op) == AOP_ADD) begin
                sum = 65'(req_i.a) + 65'(req_i.b);
              end else begin
                sum = 65'(req_i.a) - 65'(req_i.b);
              end
              acc_d = 64'(sum);
              st_d  = A_FIN;
            end
            AOP_MUL: begin
              acc_d = 64'(req_i.a) * 64'(req_i.b);
              st_d  = A_MUL;
            end
            AOP_DIV: begin
              if (req_i.b == '0) begin
                res_d  = req_i.a[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                sts_d  = ST_DIV0;
                done_d = 1'b1;
              end else begin
                dvd_d = {abs32(req_i.a), 16'd0};
                rem_d = '0;
                quo_d = '0;
                cnt_d = '0;
                st_d  = A_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      A_MUL: begin
        mag   = acc_q[63] ? -acc_q : acc_q;
        mag   = mag >>> 16;
        acc_d = acc_q[63] ? -mag : mag;
        st_d  = A_FIN;
      end
      A_DIV: begin
        if (!rem_sub[48]) begin
          rem_d = rem_sub[47:0];
          quo_d = {quo_q[46:0], 1'b1};
        end else begin
          rem_d = rem_sh[47:0];
          quo_d = {quo_q[46:0], 1'b0};
        end
        dvd_d = {dvd_q[46:0], 1'b0};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DivBits - 1)) begin
          sval  = {17'd0, quo_d};
          acc_d = neg_q ? 64'(-sval) : 64'(sval);
          st_d  = A_FIN;
        end
      end
      A_FIN: begin
        if (acc_q > 64'sh7FFF_FFFF) begin
          res_d = 32'sh7FFF_FFFF;
          sts_d = ST_OVF;
        end else if (acc_q < -64'sh8000_0000) begin
          res_d = 32'sh8000_0000;
          sts_d = ST_OVF;
        end else begin
          res_d = acc_q[31:0];
        end
        done_d = 1'b1;
        st_d   = A_IDLE;
      end
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
    sts_q <= sts_d;
    if (st_q == A_IDLE && req_i.start) begin
      dvs_q <= abs32(req_i.b);
      neg_q <= req_i.a[31] ^ req_i.b[31];
    end
  end

  assign rsp_o = '{done: done_q, res: res_q, status: sts_q};
endmodule
`default_nettype wire

### rtl/rpn_stack_calculator_core.sv
`default_nettype none
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid_i/in_ready_o | rpn_pkg::in_item_t
// out     | out | out_valid_o/out_ready_i | rpn_pkg::out_item_t
// From transfer to result: a push is written and registered to the output; a full
// push or too few operands first reads the top. Operators read both operands, run
// the ALU (divide one quotient bit a cycle over 48 bits) and write back. Copy
// writes one copy per cycle. Reduce repeats the fold, reading the next operand.
// in_ready_o is low from transfer until the result is registered; an untaken
// result holds the next one back. Reset clears the state, depth count and output valid only.
module rpn_stack_calculator_core #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire rpn_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rpn_pkg::out_item_t       out_data_o
);
  import rpn_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_e             st_q, st_d;
  in_item_t           item_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [1:0]         sts_q, sts_d;
  logic signed [31:0] b_q, b_d, a_q, a_d, top_q, top_d;
  logic [CW-1:0]      ncp_q, ncp_d;
  out_item_t          out_q, out_d;
  logic               ov_q, ov_d;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rdata;
  alu_req_t           areq;
  alu_rsp_t           arsp;
  logic [CW-1:0]      room;
  logic [15:0]        nreq;

  rpn_ram #(.Width(32), .Depth(STACK_DEPTH)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  rpn_alu u_alu (.clk_i, .rst_ni, .req_i(areq), .rsp_o(arsp));

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_comb begin
    room = CW'(STACK_DEPTH) - (cnt_q - CW'(2));
    nreq = b_q[31] ? 16'd0 : b_q[31:16];
  end

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    sts_d = sts_q;
    b_d   = b_q;
    a_d   = a_q;
    top_d = top_q;
    ncp_d = ncp_q;
    out_d = out_q;
    ov_d  = ov_q;
    we    = 1'b0;
    waddr = AW'(cnt_q - CW'(1));
    wdata = 32'(a_q);
    raddr = AW'(cnt_q - CW'(1));
    areq  = '{start: 1'b0, op: item_q.arith_op, a: a_q, b: b_q};
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sts_d = ST_OK;
          if (opn_e'(in_data_i.operation) == OPN_PUSH) begin
            if (cnt_q < CW'(STACK_DEPTH)) begin
              we    = 1'b1;
              waddr = AW'(cnt_q);
              wdata = in_data_i.push_value;
              top_d = in_data_i.push_value;
              cnt_d = cnt_q + CW'(1);
              st_d  = S_OUT;
            end else begin
              sts_d = ST_OVF;
              st_d  = S_RD_TOP;
            end
          end else if (cnt_q < CW'(2)) begin
            sts_d = ST_FEW;
            st_d  = S_RD_TOP;
          end else begin
            st_d = S_RD_B;
          end
        end
      end
      S_RD_B: begin
        raddr = AW'(cnt_q - CW'(1));
        st_d  = S_RD_A;
      end
      S_RD_A: begin
        raddr = AW'(cnt_q - CW'(2));
        b_d   = rdata;
        st_d  = S_WAIT_A;
      end
      S_WAIT_A: begin
        a_d = rdata;
        if (opn_e'(item_q.operation) == OPN_COPY) begin
          cnt_d = cnt_q - CW'(2);
          if ({{(32-CW){1'b0}}, room} < {16'd0, nreq}) begin
            ncp_d = room;
            sts_d = ST_OVF;
          end else begin
            ncp_d = CW'(nreq);
          end
          st_d = S_COPY;
        end else begin
          st_d = S_ALU;
        end
      end
      S_ALU: begin
        areq.start = 1'b1;
        st_d       = S_ALU_WAIT;
      end
      S_ALU_WAIT: begin
        if (arsp.done) begin
          a_d   = arsp.res;
          cnt_d = cnt_q - CW'(1);
          if (sts_q == ST_OK) begin
            sts_d = arsp.status;
          end
          st_d = S_WR;
        end
      end
      S_WR: begin
        we    = 1'b1;
        waddr = AW'(cnt_q - CW'(1));
        wdata = a_q;
        top_d = a_q;
        if (opn_e'(item_q.operation) == OPN_REDUCE && cnt_q > CW'(1)) begin
          b_d   = a_q;
          raddr = AW'(cnt_q - CW'(2));
          st_d  = S_WAIT_A;
        end else begin
          st_d = S_OUT;
        end
      end
      S_COPY: begin
        if (ncp_q != '0) begin
          we    = 1'b1;
          waddr = AW'(cnt_q);
          wdata = a_q;
          cnt_d = cnt_q + CW'(1);
          ncp_d = ncp_q - CW'(1);
        end else begin
          st_d = S_RD_TOP;
        end
      end
      S_RD_TOP: begin
        raddr = AW'(cnt_q - CW'(1));
        st_d  = S_TOP_WAIT;
      end
      S_TOP_WAIT: begin
        top_d = (cnt_q == '0) ? 32'sd0 : rdata;
        st_d  = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          out_d = '{top_value: top_q, stack_depth: 7'(cnt_q), status: sts_q};
          ov_d  = 1'b1;
          st_d  = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    sts_q <= sts_d;
    b_q   <= b_d;
    a_q   <= a_d;
    top_q <= top_d;
    ncp_q <= ncp_d;
    out_q <= out_d;
  end
endmodule
`default_nettype wire

### rtl/rpn_checker.sv
`default_nettype none
module rpn_core_props (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire rpn_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire rpn_pkg::out_item_t out_data_o
);
  import rpn_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready after transfer");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stack_depth == 7'd0 |-> out_data_o.top_value == 32'sd0)
    else $error("empty stack with nonzero top");

  a_few_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FEW |-> out_data_o.stack_depth < 7'd2)
    else $error("few-operand status with deep stack");
endmodule

bind rpn_stack_calculator_core rpn_core_props u_rpn_core_props (.*);
`default_nettype wire

### tb/rpn_checker.sv
module rpn_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire rpn_pkg::in_item_t  in_data_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire rpn_pkg::out_item_t out_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  import rpn_pkg::*;

  logic signed [31:0] calc_stack [STACK_DEPTH];
  int unsigned        calc_depth;
  out_item_t          expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic signed [31:0] clamp32(input longint v, inout status_e st);
    if (v > 64'sd2147483647) begin
      st = ST_OVF;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      st = ST_OVF;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fold(input logic signed [31:0] a,
                                              input logic signed [31:0] b,
                                              input aop_e op, output status_e st);
    longint wa, wb, p;
    wa = a;
    wb = b;
    st = ST_OK;
    case (op)
      AOP_ADD: return clamp32(wa + wb, st);
      AOP_SUB: return clamp32(wa - wb, st);
      AOP_MUL: begin
        p = wa * wb;
        p = (p >= 0) ? (p >>> 16) : -((-p) >>> 16);
        return clamp32(p, st);
      end
      default: begin
        if (b == 0) begin
          st = ST_DIV0;
          return (a >= 0) ? 32'sh7fffffff : 32'sh80000000;
        end
        return clamp32((wa * 65536) / wb, st);
      end
    endcase
  endfunction

  function automatic status_e apply_top(input aop_e op);
    status_e st;
    logic signed [31:0] r;
    r = fold(calc_stack[calc_depth-2], calc_stack[calc_depth-1], op, st);
    calc_depth--;
    calc_stack[calc_depth-1] = r;
    return st;
  endfunction

  function automatic out_item_t calc_step(input in_item_t it);
    out_item_t res;
    status_e st, s2;
    logic signed [31:0] cnt, val;
    int unsigned n, room;
    st = ST_OK;
    if (opn_e'(it.operation) == OPN_PUSH) begin
      if (calc_depth < STACK_DEPTH) begin
        calc_stack[calc_depth] = it.push_value;
        calc_depth++;
      end else st = ST_OVF;
    end else if (calc_depth < 2) begin
      st = ST_FEW;
    end else if (opn_e'(it.operation) == OPN_APPLY) begin
      st = apply_top(aop_e'(it.arith_op));
    end else if (opn_e'(it.operation) == OPN_COPY) begin
      cnt = calc_stack[calc_depth-1];
      val = calc_stack[calc_depth-2];
      calc_depth -= 2;
      n = (cnt > 0) ? (cnt >>> 16) : 0;
      room = STACK_DEPTH - calc_depth;
      if (n > room) begin
        n = room;
        st = ST_OVF;
      end
      repeat (n) begin
        calc_stack[calc_depth] = val;
        calc_depth++;
      end
    end else begin
      while (calc_depth > 1) begin
        s2 = apply_top(aop_e'(it.arith_op));
        if (st == ST_OK) st = s2;
      end
    end
    res.top_value   = (calc_depth > 0) ? calc_stack[calc_depth-1] : 32'sd0;
    res.stack_depth = calc_depth[6:0];
    res.status      = st;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      calc_depth   <= 0;
      fail_count_o <= 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) expected_q.push_back(calc_step(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected result %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.top_value !== out_data_i.top_value ||
              want.stack_depth !== out_data_i.stack_depth ||
              want.status !== out_data_i.status) begin
            if (fail_count_o < 10)
              $display("mismatch: expected top %0d depth %0d status %0d, got %0d %0d %0d",
                       want.top_value, want.stack_depth, want.status,
                       out_data_i.top_value, out_data_i.stack_depth, out_data_i.status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

### tb/tb_top.sv
module tb_top;
  import rpn_pkg::*;

  localparam int LIMIT = 1500000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  int        fail_count, pending;
  int        cycle_count = 0;
  int        model_depth = 0;
  int        rx_wait = 0;
  bit        long_hold = 1'b0;
  bit        sender_done = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rpn_stack_calculator_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  rpn_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("rpn_stack_calculator_core verification failed");
      $finish;
    end
  end

  // depth tracked only to keep stack usage sensible
  function automatic void track(input in_item_t it);
    case (opn_e'(it.operation))
      OPN_PUSH:   if (model_depth < 64) model_depth++;
      OPN_APPLY:  if (model_depth >= 2) model_depth--;
      OPN_COPY:   if (model_depth >= 2) model_depth = 64;
      OPN_REDUCE: if (model_depth >= 2) model_depth = 1;
    endcase
  endfunction

  // valid stays high after a transfer; it drops only for an idle gap or at the end
  task automatic send(input opn_e opn, input aop_e aop, input logic [31:0] v,
                      input bit gaps);
    int idle_cycles;
    idle_cycles = gaps ? $urandom_range(0, 13) : 0;
    if (idle_cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle_cycles) @(posedge clk_i);
    end
    in_data_i  <= '{operation: opn, arith_op: aop, push_value: v};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    track('{operation: opn, arith_op: aop, push_value: v});
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 8) << 16;
      4: return ($urandom & 32'h0003ffff) - 32'h00020000;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni || long_hold) out_ready_i <= 1'b0;
    else if (sender_done) out_ready_i <= 1'b1;
    else if (out_valid_o && out_ready_i) begin
      rx_wait = $urandom_range(0, 13);
      out_ready_i <= (rx_wait == 0);
    end else if (rx_wait != 0) begin
      rx_wait = rx_wait - 1;
      out_ready_i <= (rx_wait == 0);
    end else out_ready_i <= 1'b1;
  end

  initial begin
    int seq_len, idle;
    aop_e a;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send(OPN_APPLY, AOP_ADD, 0, 0);
    send(OPN_PUSH, AOP_ADD, 32'h7fffffff, 0);
    send(OPN_REDUCE, AOP_ADD, 0, 0);
    send(OPN_COPY, AOP_ADD, 0, 0);
    send(OPN_PUSH, AOP_ADD, 32'h7fffffff, 0);
    send(OPN_APPLY, AOP_ADD, 0, 0);
    send(OPN_PUSH, AOP_SUB, 32'h80000000, 0);
    send(OPN_APPLY, AOP_SUB, 0, 0);
    send(OPN_PUSH, AOP_ADD, 32'h80000000, 1);
    send(OPN_APPLY, AOP_MUL, 0, 1);
    send(OPN_PUSH, AOP_ADD, 32'h0, 0);
    send(OPN_APPLY, AOP_DIV, 0, 0);
    send(OPN_PUSH, AOP_ADD, 32'hfffe8000, 0);
    send(OPN_PUSH, AOP_ADD, 32'h0, 0);
    send(OPN_APPLY, AOP_DIV, 0, 0);
    send(OPN_PUSH, AOP_ADD, 32'h00000001, 0);
    send(OPN_APPLY, AOP_DIV, 0, 0);
    send(OPN_PUSH, AOP_ADD, 32'h00030000, 0);
    send(OPN_PUSH, AOP_ADD, 32'h7fffffff, 0);
    send(OPN_COPY, AOP_ADD, 0, 0);
    send(OPN_PUSH, AOP_ADD, 32'h5, 0);
    send(OPN_REDUCE, AOP_MUL, 0, 0);
    send(OPN_PUSH, AOP_ADD, 32'hffff0000, 0);
    send(OPN_COPY, AOP_ADD, 0, 0);

    // receiver stalls long while the sender keeps offering
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      repeat (6) send(OPN_PUSH, AOP_ADD, rand_value(), 0);
    join

    // sender waits until every result has been taken
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    for (int i = 0; i < 1900; ) begin
      if ($urandom_range(0, 9) < 8) begin
        // well-formed: a few pushes then operators, occasionally copy/reduce
        seq_len = $urandom_range(1, 4);
        repeat (seq_len) begin
          send(OPN_PUSH, aop_e'($urandom_range(0, 3)), rand_value(), 1);
          i++;
        end
        a = aop_e'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
          0: begin
            send(OPN_PUSH, a, $urandom_range(0, 12) << 16 | ($urandom & 16'hffff), 1);
            send(OPN_COPY, a, 0, 1);
            i += 2;
          end
          1: if (model_depth < 12) begin
            send(OPN_REDUCE, a, 0, 1);
            i++;
          end
          default: begin
            send(OPN_APPLY, a, 0, 1);
            i++;
          end
        endcase
        if (model_depth > 40) begin
          send(OPN_REDUCE, aop_e'($urandom_range(0, 2)), 0, 1);
          i++;
        end
      end else begin
        idle = $urandom_range(0, 1);
        send(opn_e'($urandom_range(0, 3)), aop_e'($urandom_range(0, 3)),
             $urandom, idle[0]);
        i++;
      end
    end

    in_valid_i <= 1'b0;
    sender_done = 1'b1;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("rpn_stack_calculator_core verification clean");
    else $display("rpn_stack_calculator_core verification failed");
    $finish;
  end
endmodule

### sim.f
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_alu.sv
rtl/rpn_stack_calculator_core.sv
rtl/rpn_checker.sv
tb/rpn_checker.sv
tb/tb_top.sv
